/* hdl/mesh_flood_dedup_relay_macros.svh */
// Assertion macros for the mesh flood relay checker.
// Depends on nothing; included by the checker file only.
`ifndef MESH_FLOOD_DEDUP_RELAY_MACROS_SVH
`define MESH_FLOOD_DEDUP_RELAY_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MFDR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mesh flood relay check failed");

// Check a condition in the cycle after its trigger.
`define MFDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mesh flood relay check failed");

`endif

/* hdl/mfdr_pkg.sv */
// Shared constants and codes for the mesh flood relay.
// Depends on nothing; imported by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mfdr_pkg;

    // Sizing of the per-port id caches
    localparam int MAX_PORTS   = 4;
    localparam int CACHE_DEPTH = 16;
    localparam int PORT_W      = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int SLOT_W      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int SCNT_W      = $clog2(CACHE_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_PORTS + 1);
    localparam int STORE_DEPTH = MAX_PORTS * CACHE_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Field widths
    localparam int ID_W      = 16;
    localparam int PEND_W    = 4;
    localparam int PFIELD_W  = 2;
    localparam int VERDICT_W = 3;
    localparam int PIU_W     = 3;
    localparam int ECHO_W    = 4;
    localparam int CFG_W     = 4;
    localparam int TDATA_W   = 24;

    // Configuration register indexes
    localparam logic REG_PORTS_IN_USE = 1'b0;
    localparam logic REG_ECHO_MASK    = 1'b1;

    // Input kinds
    localparam logic KIND_RECEIVE = 1'b0;
    localparam logic KIND_SEND    = 1'b1;

    // Result actions
    localparam logic ACT_FORWARD = 1'b0;
    localparam logic ACT_VERDICT = 1'b1;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERD_DELIVERED  = 3'd0;
    localparam logic [VERDICT_W-1:0] VERD_NONE       = 3'd1;
    localparam logic [VERDICT_W-1:0] VERD_INVALID    = 3'd2;
    localparam logic [VERDICT_W-1:0] VERD_DUPLICATE  = 3'd3;
    localparam logic [VERDICT_W-1:0] VERD_ORIGINATED = 3'd4;

endpackage

`default_nettype wire

/* hdl/mfdr_ram.sv */
// Generic simple dual-port RAM with registered read.
// Depends on nothing; holds the per-port recent id caches.
`timescale 1ns / 1ps
`default_nettype none

module mfdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one word, read one word a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* hdl/mesh_flood_dedup_relay.sv */
// Flooding relay with a recent-id duplicate cache per radio port.
// Depends on mfdr_pkg and mfdr_ram.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_axis   | in  | tvalid/tready           | tuser kind; tdata pending, id, valid
//  m_axis   | out | tvalid/tready, tlast    | tuser action; tdata port, id, verdict
//  cfg      | in  | cfg_we, no wait         | cfg_index selects register, cfg_data
//
// One comparator checks one cache entry a cycle.
// Receive: cursor wrap, a round-robin grant search, one scan of the source cache and,
// unless it holds the id, one scan per port in use, then the verdict.
// Send: one forward per port in use, then the verdict.
// Reset clears the caches at once through per-entry valid bits; a stalled output holds
// the sequencer where it would emit, and a new item is taken only between items.
`timescale 1ns / 1ps
`default_nettype none

module mesh_flood_dedup_relay
    import mfdr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // s_axis_tdata: pending_mask[3:0], pkt_id[19:4], packet_valid[20], zero pad
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [TDATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: kind[0]
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // m_axis_tdata: port[1:0], out_id[17:2], verdict[20:18], zero pad
    output logic      [TDATA_W-1:0]   m_axis_tdata,
    // m_axis_tuser: action[0]
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NORM   = 3'd1;
    localparam logic [2:0] S_GRANT  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_SEND   = 3'd5;
    localparam logic [2:0] S_VERD   = 3'd6;

    localparam logic MODE_DUP = 1'b0;
    localparam logic MODE_FWD = 1'b1;

    // Control state
    logic [2:0]            state_reg, state_next;
    logic [PORT_W-1:0]     cursor_reg, cursor_next;
    logic [PORT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]      grant_cnt_reg, grant_cnt_next;
    logic [PORT_W-1:0]     src_reg, src_next;
    logic [PORT_W-1:0]     fp_reg, fp_next;
    logic [PORT_W-1:0]     scan_port_reg, scan_port_next;
    logic [SCNT_W-1:0]     scan_k_reg, scan_k_next;
    logic                  mode_reg, mode_next;
    logic                  hit_reg, hit_next;
    logic                  cmp_v_reg, cmp_last_reg;
    logic [VERDICT_W-1:0]  verdict_reg, verdict_next;
    logic [PORT_W-1:0]     vport_reg, vport_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [PIU_W-1:0]      ports_reg;
    logic [ECHO_W-1:0]     echo_reg;
    logic [SLOT_W-1:0]     wp_reg [MAX_PORTS];
    logic                  vld_reg [STORE_DEPTH];
    logic                  vld_rd_reg;

    // Item payload
    logic [PEND_W-1:0]     pending_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  pvalid_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_action_reg;
    logic [PORT_W-1:0]     out_port_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic [VERDICT_W-1:0]  out_verdict_reg;
    logic                  out_last_reg;

    // Datapath nets
    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    logic                  ld_action;
    logic [PORT_W-1:0]     ld_port;
    logic [VERDICT_W-1:0]  ld_verdict;
    logic                  ld_last;
    logic                  ram_we;
    logic [PORT_W-1:0]     wr_port;
    logic [SLOT_W-1:0]     wr_slot;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [ID_W-1:0]       rdata;
    logic [ID_W-1:0]       entry;
    logic                  rd_issue;
    logic                  match;
    logic [CNT_W-1:0]      n_active;
    logic [PORT_W-1:0]     pos_inc;
    logic [PORT_W-1:0]     fp_last;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Clamp the configured port count to 1..MAX_PORTS
    always_comb
    begin
        if (ports_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(ports_reg) > MAX_PORTS)
        begin
            n_active = CNT_W'(MAX_PORTS);
        end
        else
        begin
            n_active = CNT_W'(ports_reg);
        end
    end

    assign pos_inc = (CNT_W'(pos_reg) == n_reg - CNT_W'(1)) ? '0 : pos_reg + PORT_W'(1);
    assign fp_last = PORT_W'(n_reg - CNT_W'(1));

    // Cache read and the shared comparator
    assign rd_issue = (state_reg == S_SCAN) && (scan_k_reg < SCNT_W'(CACHE_DEPTH));
    assign raddr    = ADDR_W'(scan_port_reg) * ADDR_W'(CACHE_DEPTH)
                    + ADDR_W'(scan_k_reg[SLOT_W-1:0]);
    assign entry    = vld_rd_reg ? rdata : '0;
    assign match    = cmp_v_reg && (entry == id_reg);
    assign wr_slot  = wp_reg[wr_port];
    assign waddr    = ADDR_W'(wr_port) * ADDR_W'(CACHE_DEPTH) + ADDR_W'(wr_slot);

    mfdr_ram #(
        .WIDTH(ID_W),
        .DEPTH(STORE_DEPTH)
    ) u_cache (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr),
        .wdata(id_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        pos_next       = pos_reg;
        grant_cnt_next = grant_cnt_reg;
        src_next       = src_reg;
        fp_next        = fp_reg;
        scan_port_next = scan_port_reg;
        scan_k_next    = scan_k_reg;
        mode_next      = mode_reg;
        hit_next       = hit_reg | match;
        verdict_next   = verdict_reg;
        vport_next     = vport_reg;
        n_next         = n_reg;
        load_out       = 1'b0;
        ld_action      = ACT_FORWARD;
        ld_port        = fp_reg;
        ld_verdict     = VERD_DELIVERED;
        ld_last        = 1'b0;
        ram_we         = 1'b0;
        wr_port        = fp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next         = n_active;
                    pos_next       = cursor_reg;
                    grant_cnt_next = '0;
                    fp_next        = '0;
                    state_next     = (s_axis_tuser == KIND_SEND) ? S_SEND : S_NORM;
                end
            end

            // Wrap a cursor left beyond a reduced port count
            S_NORM:
            begin
                if (CNT_W'(pos_reg) >= n_reg)
                begin
                    pos_next = PORT_W'(CNT_W'(pos_reg) - n_reg);
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end

            // Round-robin search for a pending port, one port a cycle
            S_GRANT:
            begin
                if (grant_cnt_reg == n_reg)
                begin
                    verdict_next = VERD_NONE;
                    vport_next   = '0;
                    state_next   = S_VERD;
                end
                else if ((32'(pos_reg) < PEND_W) && pending_reg[pos_reg])
                begin
                    src_next    = pos_reg;
                    cursor_next = pos_inc;
                    if (!pvalid_reg)
                    begin
                        verdict_next = VERD_INVALID;
                        vport_next   = pos_reg;
                        state_next   = S_VERD;
                    end
                    else
                    begin
                        mode_next      = MODE_DUP;
                        scan_port_next = pos_reg;
                        scan_k_next    = '0;
                        hit_next       = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    pos_next       = pos_inc;
                    grant_cnt_next = grant_cnt_reg + CNT_W'(1);
                end
            end

            // Stream one cache through the comparator
            S_SCAN:
            begin
                if (rd_issue)
                begin
                    scan_k_next = scan_k_reg + SCNT_W'(1);
                end
                if (cmp_v_reg && cmp_last_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (mode_reg == MODE_DUP)
                begin
                    if (hit_reg)
                    begin
                        verdict_next = VERD_DUPLICATE;
                        vport_next   = src_reg;
                        state_next   = S_VERD;
                    end
                    else
                    begin
                        // Seed the source cache unless it echoes to its source
                        ram_we         = !((32'(src_reg) < ECHO_W) && echo_reg[src_reg]);
                        wr_port        = src_reg;
                        mode_next      = MODE_FWD;
                        fp_next        = '0;
                        scan_port_next = '0;
                        scan_k_next    = '0;
                        hit_next       = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
                else if (hit_reg || out_free)
                begin
                    // Forward and record on a port that lacks the id
                    if (!hit_reg)
                    begin
                        ram_we   = 1'b1;
                        wr_port  = fp_reg;
                        load_out = 1'b1;
                    end
                    if (fp_reg == fp_last)
                    begin
                        verdict_next = VERD_DELIVERED;
                        vport_next   = src_reg;
                        state_next   = S_VERD;
                    end
                    else
                    begin
                        fp_next        = fp_reg + PORT_W'(1);
                        scan_port_next = fp_reg + PORT_W'(1);
                        scan_k_next    = '0;
                        hit_next       = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            // Flood an originated id on every port in use
            S_SEND:
            begin
                if (out_free)
                begin
                    ram_we   = 1'b1;
                    wr_port  = fp_reg;
                    load_out = 1'b1;
                    if (fp_reg == fp_last)
                    begin
                        verdict_next = VERD_ORIGINATED;
                        vport_next   = '0;
                        state_next   = S_VERD;
                    end
                    else
                    begin
                        fp_next = fp_reg + PORT_W'(1);
                    end
                end
            end

            S_VERD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ld_action  = ACT_VERDICT;
                    ld_port    = vport_reg;
                    ld_verdict = verdict_reg;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            cmp_v_reg     <= 1'b0;
            cmp_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ports_reg     <= PIU_W'(1);
            echo_reg      <= '0;
            for (int p = 0; p < MAX_PORTS; p++)
            begin
                wp_reg[p] <= '0;
            end
            for (int e = 0; e < STORE_DEPTH; e++)
            begin
                vld_reg[e] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            cmp_v_reg     <= rd_issue;
            cmp_last_reg  <= rd_issue && (scan_k_reg == SCNT_W'(CACHE_DEPTH - 1));
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PORTS_IN_USE: ports_reg <= cfg_data[PIU_W-1:0];
                    REG_ECHO_MASK:    echo_reg  <= cfg_data[ECHO_W-1:0];
                    default:          ports_reg <= ports_reg;
                endcase
            end
            // Record an id: mark the slot and advance the ring pointer
            if (ram_we)
            begin
                vld_reg[waddr]  <= 1'b1;
                wp_reg[wr_port] <= (wr_slot == SLOT_W'(CACHE_DEPTH - 1)) ? '0
                                                                          : wr_slot + SLOT_W'(1);
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        grant_cnt_reg <= grant_cnt_next;
        src_reg       <= src_next;
        fp_reg        <= fp_next;
        scan_port_reg <= scan_port_next;
        scan_k_reg    <= scan_k_next;
        mode_reg      <= mode_next;
        hit_reg       <= hit_next;
        verdict_reg   <= verdict_next;
        vport_reg     <= vport_next;
        n_reg         <= n_next;
        vld_rd_reg    <= vld_reg[raddr];
        if (accept)
        begin
            pending_reg <= s_axis_tdata[PEND_W-1:0];
            id_reg      <= s_axis_tdata[PEND_W +: ID_W];
            pvalid_reg  <= s_axis_tdata[PEND_W + ID_W];
        end
        if (load_out)
        begin
            out_action_reg  <= ld_action;
            out_port_reg    <= ld_port;
            out_id_reg      <= id_reg;
            out_verdict_reg <= ld_verdict;
            out_last_reg    <= ld_last;
        end
    end

    // Drive the result transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(TDATA_W - PFIELD_W - ID_W - VERDICT_W)'(0),
                            out_verdict_reg, out_id_reg, PFIELD_W'(out_port_reg)};

endmodule

`default_nettype wire

/* hdl/mfdr_checker.sv */
// Port-level checks for the mesh flood relay, bound to the top level.
// Depends on mfdr_pkg and mesh_flood_dedup_relay_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "mesh_flood_dedup_relay_macros.svh"

module mfdr_checker
    import mfdr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic               m_axis_tuser,
    input wire logic               m_axis_tlast
);

    // A stalled result holds its payload
    `MFDR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // An accepted item occupies the sequencer for the next cycle
    `MFDR_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A forward transfer never closes an item and carries no verdict
    `MFDR_ASSERT_SAME(a_fwd_shape, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ACT_FORWARD), !m_axis_tlast && (m_axis_tdata[20:18] == VERD_DELIVERED))

    // A verdict transfer always closes its item
    `MFDR_ASSERT_SAME(a_verdict_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ACT_VERDICT), m_axis_tlast)

endmodule

bind mesh_flood_dedup_relay mfdr_checker u_mfdr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

/* test/tb_mesh_flood_dedup_relay.sv */
// Self-checking testbench for the mesh flood relay with per-port duplicate caches.
// Depends on mfdr_pkg and mesh_flood_dedup_relay; predicts every result in-bench.
`timescale 1ns / 1ps

module tb_mesh_flood_dedup_relay;
    import mfdr_pkg::*;

    localparam int LONG_STALL   = 300;
    localparam int SETTLE_WAIT  = 200;
    localparam int ITEMS_PHASE  = 50;

    typedef struct packed {
        logic                  kind;
        logic [PEND_W-1:0]     pending;
        logic [ID_W-1:0]       pkt_id;
        logic                  pkt_valid;
    } relay_item_t;

    typedef struct packed {
        logic                  action;
        logic [PFIELD_W-1:0]   port;
        logic [ID_W-1:0]       pkt_id;
        logic [VERDICT_W-1:0]  verdict;
        logic                  last;
    } relay_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                cfg_we = 1'b0;
    logic                cfg_index = REG_PORTS_IN_USE;
    logic [CFG_W-1:0]    cfg_data = '0;

    // Predictor state and its copy of the registers
    logic [1:0]          relay_cursor;
    logic [ID_W-1:0]     id_cache [STORE_DEPTH];
    int                  cache_wptr [MAX_PORTS];
    logic [PIU_W-1:0]    cfg_ports;
    logic [ECHO_W-1:0]   cfg_echo;

    relay_item_t         relay_items[$];
    relay_result_t       expected_results[$];
    relay_item_t         offer_item;

    int                  send_gap = 0;
    int                  rx_wait = 0;
    bit                  idle_on = 1'b1;
    logic                rx_hold = 1'b0;
    bit                  stall_go = 1'b0;
    int                  err_count = 0;
    int                  items_accepted = 0;
    int                  sends_accepted = 0;
    int                  results_seen = 0;
    int                  verdict_seen [5];
    logic [ID_W-1:0]     id_pool [8];

    mesh_flood_dedup_relay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Cache helpers for the predictor
    function automatic bit cache_has(input int p, input logic [ID_W-1:0] id);
        for (int k = 0; k < CACHE_DEPTH; k++)
            if (id_cache[p * CACHE_DEPTH + k] == id) return 1'b1;
        return 1'b0;
    endfunction

    task automatic cache_put(input int p, input logic [ID_W-1:0] id);
        id_cache[p * CACHE_DEPTH + cache_wptr[p]] = id;
        cache_wptr[p] = (cache_wptr[p] + 1) % CACHE_DEPTH;
    endtask

    task automatic push_result(input logic act, input int port, input logic [ID_W-1:0] id,
                               input logic [VERDICT_W-1:0] verd, input logic last);
        relay_result_t r;
        r.action  = act;
        r.port    = PFIELD_W'(port);
        r.pkt_id  = id;
        r.verdict = verd;
        r.last    = last;
        expected_results.push_back(r);
    endtask

    // Work out every result one accepted item causes
    task automatic predict_relay(input relay_item_t it);
        int  n;
        int  src;
        int  p;
        bit  found;
        n = (cfg_ports == 0) ? 1 : ((cfg_ports > MAX_PORTS) ? MAX_PORTS : int'(cfg_ports));
        if (it.kind == KIND_SEND) begin
            // Forward results carry a zero verdict
            for (int q = 0; q < n; q++) begin
                push_result(ACT_FORWARD, q, it.pkt_id, VERD_DELIVERED, 1'b0);
                cache_put(q, it.pkt_id);
            end
            push_result(ACT_VERDICT, 0, it.pkt_id, VERD_ORIGINATED, 1'b1);
            return;
        end
        found = 1'b0;
        src = 0;
        for (int i = 0; i < n && !found; i++) begin
            p = (int'(relay_cursor) + i) % n;
            if (it.pending[p]) begin
                src = p;
                found = 1'b1;
            end
        end
        if (!found) begin
            push_result(ACT_VERDICT, 0, it.pkt_id, VERD_NONE, 1'b1);
            return;
        end
        relay_cursor = 2'((src + 1) % n);
        if (!it.pkt_valid) begin
            push_result(ACT_VERDICT, src, it.pkt_id, VERD_INVALID, 1'b1);
            return;
        end
        if (cache_has(src, it.pkt_id)) begin
            push_result(ACT_VERDICT, src, it.pkt_id, VERD_DUPLICATE, 1'b1);
            return;
        end
        if (!cfg_echo[src]) cache_put(src, it.pkt_id);
        for (int q = 0; q < n; q++) begin
            if (!cache_has(q, it.pkt_id)) begin
                cache_put(q, it.pkt_id);
                push_result(ACT_FORWARD, q, it.pkt_id, VERD_DELIVERED, 1'b0);
            end
        end
        push_result(ACT_VERDICT, src, it.pkt_id, VERD_DELIVERED, 1'b1);
    endtask

    // Driver: offer queued items, predict on each transfer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_gap      <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_relay(offer_item);
                items_accepted++;
                if (offer_item.kind == KIND_SEND) sends_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (relay_items.size() > 0) begin
                    offer_item    = relay_items.pop_front();
                    s_axis_tdata  <= TDATA_W'({offer_item.pkt_valid, offer_item.pkt_id,
                                               offer_item.pending});
                    s_axis_tuser  <= offer_item.kind;
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= idle_on ? $urandom_range(0, 3) : 0;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        relay_result_t exp_r;
        int            w;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end
        else begin
            w = rx_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                    err_count++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    check_field("action", exp_r.action, m_axis_tuser);
                    check_field("port", exp_r.port, m_axis_tdata[1:0]);
                    check_field("out_id", exp_r.pkt_id, m_axis_tdata[17:2]);
                    check_field("verdict", exp_r.verdict, m_axis_tdata[20:18]);
                    check_field("last", exp_r.last, m_axis_tlast);
                    if (exp_r.action == ACT_VERDICT && exp_r.verdict < 5)
                        verdict_seen[exp_r.verdict]++;
                end
                w = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                rx_wait       <= w;
            end
            else if (w > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait       <= w - 1;
            end
            else begin
                m_axis_tready <= 1'b1;
                rx_wait       <= 0;
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin
        wait (stall_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_item(input logic kind, input logic [PEND_W-1:0] pend,
                             input logic [ID_W-1:0] id, input logic valid);
        relay_item_t it;
        it.kind      = kind;
        it.pending   = pend;
        it.pkt_id    = id;
        it.pkt_valid = valid;
        relay_items.push_back(it);
    endtask

    // Hold until every queued item is taken and every result has come back
    task automatic wait_drained();
        do @(posedge clk);
        while (relay_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_PORTS_IN_USE) cfg_ports = val[PIU_W-1:0];
        else cfg_echo = val[ECHO_W-1:0];
    endtask

    // Mostly well-formed receive polls on a small id pool, so duplicates are common
    task automatic push_random_item();
        logic               kind;
        logic [PEND_W-1:0]  pend;
        logic [ID_W-1:0]    id;
        logic               valid;
        kind  = ($urandom_range(0, 99) < 15) ? KIND_SEND : KIND_RECEIVE;
        pend  = ($urandom_range(0, 99) < 80) ? PEND_W'($urandom_range(1, 15))
                                             : PEND_W'($urandom_range(0, 15));
        id    = ($urandom_range(0, 99) < 60) ? id_pool[$urandom_range(0, 7)]
                                             : ID_W'($urandom);
        valid = ($urandom_range(0, 99) < 85);
        push_item(kind, pend, id, valid);
    endtask

    initial begin
        logic [PIU_W-1:0]   ph_ports [7];
        logic [ECHO_W-1:0]  ph_echo [7];
        relay_cursor = '0;
        cfg_ports    = 3'd1;
        cfg_echo     = '0;
        for (int i = 0; i < STORE_DEPTH; i++) id_cache[i] = '0;
        for (int i = 0; i < MAX_PORTS; i++) cache_wptr[i] = 0;
        for (int i = 0; i < 5; i++) verdict_seen[i] = 0;
        id_pool[0] = '0;
        for (int i = 1; i < 8; i++) id_pool[i] = ID_W'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: nothing pending, id zero hits a cleared entry, unused ports
        push_item(KIND_RECEIVE, 4'b0000, 16'h5555, 1'b1);
        push_item(KIND_RECEIVE, 4'b0001, 16'h0000, 1'b1);
        push_item(KIND_RECEIVE, 4'b1110, 16'h7777, 1'b1);
        wait_drained();

        write_reg(REG_PORTS_IN_USE, 4'd4);
        write_reg(REG_ECHO_MASK, 4'b0101);
        push_item(KIND_SEND, 4'b0000, 16'hFFFF, 1'b0);
        push_item(KIND_RECEIVE, 4'b1111, 16'hFFFF, 1'b1);
        push_item(KIND_RECEIVE, 4'b1000, 16'h1234, 1'b1);
        push_item(KIND_RECEIVE, 4'b1111, 16'h8000, 1'b0);
        push_item(KIND_RECEIVE, 4'b0001, 16'h1234, 1'b1);
        push_item(KIND_RECEIVE, 4'b0101, 16'h0001, 1'b1);
        push_item(KIND_RECEIVE, 4'b0000, 16'hABCD, 1'b1);
        push_item(KIND_SEND, 4'b1111, 16'h0000, 1'b1);
        push_item(KIND_RECEIVE, 4'b0100, 16'h3333, 1'b1);
        wait_drained();

        // Cursor left past the new port count
        write_reg(REG_PORTS_IN_USE, 4'd2);
        push_item(KIND_RECEIVE, 4'b0011, 16'h4444, 1'b1);
        push_item(KIND_RECEIVE, 4'b1100, 16'h5555, 1'b1);
        wait_drained();

        // Port counts out of range: zero and above the maximum
        write_reg(REG_PORTS_IN_USE, 4'd0);
        write_reg(REG_ECHO_MASK, 4'b1111);
        push_item(KIND_RECEIVE, 4'b0001, 16'h6666, 1'b1);
        push_item(KIND_SEND, 4'b0000, 16'h0F0F, 1'b1);
        wait_drained();

        write_reg(REG_PORTS_IN_USE, 4'd7);
        write_reg(REG_ECHO_MASK, 4'b1010);
        push_item(KIND_RECEIVE, 4'b1111, 16'h9999, 1'b1);
        push_item(KIND_SEND, 4'b0000, 16'hF0F0, 1'b1);
        push_item(KIND_RECEIVE, 4'b0010, 16'h9999, 1'b1);
        wait_drained();

        // Random phases over several register settings
        ph_ports = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd4};
        ph_echo  = '{4'b0000, 4'b1111, 4'b1010, ECHO_W'($urandom), ECHO_W'($urandom),
                     ECHO_W'($urandom), 4'b0000};
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_PORTS_IN_USE, CFG_W'(ph_ports[ph]));
            write_reg(REG_ECHO_MASK, ph_echo[ph]);
            idle_on = (ph % 3 != 2);
            for (int i = 0; i < ITEMS_PHASE; i++) push_random_item();
            if (ph == 1) stall_go = 1'b1;
            wait_drained();
        end

        repeat (SETTLE_WAIT) @(posedge clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results expected, actual none arrived", $time,
                     expected_results.size());
            err_count++;
        end

        $display("Ran %0d items (%0d sends) through 12 register settings, %0d results checked.",
                 items_accepted, sends_accepted, results_seen);
        $display("Verdicts: delivered %0d, none pending %0d, invalid %0d, duplicate %0d.",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
